// ----- hw/rtl/amm_pkg.sv -----
// ----------------------------------------------------------------------------
// amm_pkg
// Shared types and constants of the ADC moving mean and altitude block.
// ----------------------------------------------------------------------------
package amm_pkg;

    // field widths
    localparam int DATA_W      = 12;
    localparam int PCT_W       = 20;
    localparam int CFG_INDEX_W = 4;

    // percentage divider: dividend width, two quotient bits per cycle
    localparam int DIV_W     = 20;
    localparam int DIV_STEPS = DIV_W / 2;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // percentage scale
    localparam int PCT_SCALE = 100;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_ZERO_LEVEL    = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_ONE_VOLT_SPAN = CFG_INDEX_W'(1);

    // register reset values
    localparam logic [DATA_W-1:0] ZERO_LEVEL_RESET = DATA_W'(0);
    localparam logic [DATA_W-1:0] SPAN_RESET       = DATA_W'(1241);

    // sequencer states
    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_UPD  = 6'b000010,
        ST_MDIV = 6'b000100,
        ST_MUL  = 6'b001000,
        ST_PDIV = 6'b010000,
        ST_DONE = 6'b100000
    } state_t;

endpackage

// ----- hw/rtl/amm_ram.sv -----
// ----------------------------------------------------------------------------
// amm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module amm_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 8
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/adc_moving_mean_altitude_percent_core.sv -----
// ----------------------------------------------------------------------------
// adc_moving_mean_altitude_percent_core
// Boxcar moving mean of 12-bit ADC samples with an altitude percentage.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_ready, sample): one ADC conversion per item.
//   out channel (out_valid/out_ready, window_mean, altitude_percent): one
//   result item per input item, in order.
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 is
//   zero_level, index 1 is one_volt_span, other indexes are ignored. Always
//   ready; write only while the block is idle.
// Sequence:
//   after an item is accepted the block runs an update step, a reciprocal
//   multiply for the mean, a scaling step, the percentage division at two
//   quotient bits per cycle and an output step that raises out_valid. The
//   next item is accepted only once the block is back in idle.
// Reset:
//   the ring reads as all zero (per-slot valid bits), the total and the
//   write slot clear, registers return to zero_level 0 and span 1241.
// Stall:
//   a result waits in the output register; the next item is accepted and
//   processed, and holds in its last step until the output register frees.
// ----------------------------------------------------------------------------
module adc_moving_mean_altitude_percent_core #(
    parameter int WINDOW_LEN = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [amm_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [amm_pkg::DATA_W-1:0]          cfg_data,
    // input items
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [amm_pkg::DATA_W-1:0]          sample,
    // result items
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [amm_pkg::DATA_W-1:0]          window_mean,
    output logic signed [amm_pkg::PCT_W-1:0]    altitude_percent
);

    localparam int ADDR_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int HALF   = WINDOW_LEN / 2;
    localparam int SUM_W  = $clog2(WINDOW_LEN * 4095 + HALF + 1);
    localparam int DW     = amm_pkg::DATA_W;
    localparam int DIV_W  = amm_pkg::DIV_W;
    localparam int CNT_W  = amm_pkg::CNT_W;

    // mean by reciprocal multiplication, exact for every dividend below 2**SUM_W
    localparam int RECIP_SHIFT = SUM_W + ADDR_W;
    localparam int RECIP_W     = SUM_W + 2;
    localparam int RECIP       = ((1 << RECIP_SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN;
    localparam int PROD_W      = SUM_W + RECIP_W;

    amm_pkg::state_t state_reg, state_next;

    logic [DW-1:0]         zero_level_reg;
    logic [DW-1:0]         span_reg;
    logic [DW-1:0]         sample_reg;
    logic [ADDR_W-1:0]     slot_reg;
    logic [WINDOW_LEN-1:0] slot_valid_reg;
    logic [SUM_W-1:0]      total_reg;
    logic [SUM_W-1:0]      dividend_reg;
    logic [DW-1:0]         mean_reg;

    logic [DW-1:0]         rem_reg;
    logic [DIV_W-1:0]      quo_reg;
    logic [DW-1:0]         den_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  neg_reg;

    logic                  out_valid_reg;
    logic [DW-1:0]         window_mean_reg;
    logic [amm_pkg::PCT_W-1:0] altitude_percent_reg;

    logic [DW-1:0]         ram_rdata;
    logic [DW-1:0]         old_sample;
    logic [SUM_W-1:0]      total_next;
    logic [SUM_W-1:0]      mean_dividend;
    logic [PROD_W-1:0]     mean_prod;
    logic                  ram_we;
    logic                  in_accept;
    logic                  out_load;

    logic [DW-1:0]         rem_step;
    logic [DIV_W-1:0]      quo_step;

    logic signed [DW:0]    diff;
    logic signed [amm_pkg::PCT_W:0] prod;
    logic [amm_pkg::PCT_W:0] prod_mag;
    logic [DW-1:0]         span_eff;
    logic [amm_pkg::PCT_W-1:0] pct_value;

    // handshakes
    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == amm_pkg::ST_IDLE);
    assign in_accept = in_valid && in_ready;
    assign out_load  = (state_reg == amm_pkg::ST_DONE) && (!out_valid_reg || out_ready);

    // sample ring
    assign ram_we = (state_reg == amm_pkg::ST_UPD);

    amm_ram #(
        .WIDTH (DW),
        .DEPTH (WINDOW_LEN)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (sample_reg),
        .raddr (slot_reg),
        .rdata (ram_rdata)
    );

    // oldest sample, zero until its slot is first written
    assign old_sample    = slot_valid_reg[slot_reg] ? ram_rdata : '0;
    assign total_next    = total_reg - SUM_W'(old_sample) + SUM_W'(sample_reg);
    assign mean_dividend = total_next + SUM_W'(HALF);

    // rounded mean as dividend times reciprocal
    assign mean_prod = PROD_W'(dividend_reg) * PROD_W'(RECIP);

    // two restoring division steps per cycle
    always_comb
    begin
        logic [DW:0]      t;
        logic [DW-1:0]    r;
        logic [DIV_W-1:0] q;
        r = rem_reg;
        q = quo_reg;
        for (int i = 0; i < 2; i++)
        begin
            t = {r, q[DIV_W-1]};
            q = {q[DIV_W-2:0], 1'b0};
            if (t >= {1'b0, den_reg})
            begin
                t    = t - {1'b0, den_reg};
                q[0] = 1'b1;
            end
            r = t[DW-1:0];
        end
        rem_step = r;
        quo_step = q;
    end

    // scaled difference and its magnitude
    assign diff     = $signed({1'b0, zero_level_reg}) - $signed({1'b0, mean_reg});
    assign prod     = (amm_pkg::PCT_W+1)'(diff) * (amm_pkg::PCT_W+1)'(amm_pkg::PCT_SCALE);
    assign prod_mag = prod[amm_pkg::PCT_W] ? (amm_pkg::PCT_W+1)'(-prod)
                                           : (amm_pkg::PCT_W+1)'(prod);
    assign span_eff = (span_reg == '0) ? DW'(1) : span_reg;
    assign pct_value = neg_reg ? (~quo_reg + DIV_W'(1)) : quo_reg;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            amm_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = amm_pkg::ST_UPD;
                end
            end
            amm_pkg::ST_UPD:
            begin
                state_next = amm_pkg::ST_MDIV;
            end
            amm_pkg::ST_MDIV:
            begin
                state_next = amm_pkg::ST_MUL;
            end
            amm_pkg::ST_MUL:
            begin
                state_next = amm_pkg::ST_PDIV;
            end
            amm_pkg::ST_PDIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = amm_pkg::ST_DONE;
                end
            end
            amm_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = amm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = amm_pkg::ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= amm_pkg::ST_IDLE;
            zero_level_reg <= amm_pkg::ZERO_LEVEL_RESET;
            span_reg       <= amm_pkg::SPAN_RESET;
            slot_reg       <= '0;
            slot_valid_reg <= '0;
            total_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // configuration writes
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == amm_pkg::REG_ZERO_LEVEL)
                begin
                    zero_level_reg <= cfg_data;
                end
                else if (cfg_index == amm_pkg::REG_ONE_VOLT_SPAN)
                begin
                    span_reg <= cfg_data;
                end
            end

            // ring bookkeeping
            if (state_reg == amm_pkg::ST_UPD)
            begin
                total_reg                <= total_next;
                slot_valid_reg[slot_reg] <= 1'b1;
                if (slot_reg == ADDR_W'(WINDOW_LEN - 1))
                begin
                    slot_reg <= '0;
                end
                else
                begin
                    slot_reg <= slot_reg + ADDR_W'(1);
                end
            end

            // output register valid
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            sample_reg <= sample;
        end

        unique case (state_reg)
            amm_pkg::ST_UPD:
            begin
                dividend_reg <= mean_dividend;
            end
            amm_pkg::ST_MDIV:
            begin
                mean_reg <= mean_prod[RECIP_SHIFT +: DW];
            end
            amm_pkg::ST_MUL:
            begin
                rem_reg <= '0;
                quo_reg <= prod_mag[DIV_W-1:0];
                den_reg <= span_eff;
                neg_reg <= prod[amm_pkg::PCT_W];
                cnt_reg <= CNT_W'(amm_pkg::DIV_STEPS - 1);
            end
            amm_pkg::ST_PDIV:
            begin
                rem_reg <= rem_step;
                quo_reg <= quo_step;
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            amm_pkg::ST_IDLE,
            amm_pkg::ST_DONE:
            begin
                cnt_reg <= cnt_reg;
            end
            default:
            begin
                cnt_reg <= cnt_reg;
            end
        endcase

        // result item
        if (out_load)
        begin
            window_mean_reg      <= mean_reg;
            altitude_percent_reg <= pct_value;
        end
    end

    assign out_valid        = out_valid_reg;
    assign window_mean      = window_mean_reg;
    assign altitude_percent = $signed(altitude_percent_reg);

endmodule

// ----- tb/sv/adc_moving_mean_altitude_percent_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_moving_mean_altitude_percent_core_tb
// Drives ADC samples and register writes into the moving mean core. It keeps
// its own copy of the sample ring, the total and the registers, predicts the
// mean and altitude reading of every accepted item, and checks each result
// item in order. The run goes through several register settings and idling
// patterns, and includes a long receiver hold-off.
// ----------------------------------------------------------------------------
module adc_moving_mean_altitude_percent_core_tb;

    localparam int DATA_W      = amm_pkg::DATA_W;
    localparam int PCT_W       = amm_pkg::PCT_W;
    localparam int CFG_INDEX_W = amm_pkg::CFG_INDEX_W;
    localparam int PCT_SCALE   = amm_pkg::PCT_SCALE;

    localparam int CLK_PERIOD      = 10;
    localparam int WINDOW_LEN      = 8;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 75;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 30;

    // register indexes that map to nothing
    localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED_FIRST = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED_LAST  = '1;

    localparam logic [DATA_W-1:0] SAMPLE_MAX = '1;

    typedef struct packed {
        logic [DATA_W-1:0]        mean;
        logic signed [PCT_W-1:0]  pct;
    } reading_t;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_W-1:0]    cfg_index = '0;
    logic [DATA_W-1:0]         cfg_data  = '0;
    logic                      in_valid  = 1'b0;
    logic                      in_ready;
    logic [DATA_W-1:0]         sample    = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [DATA_W-1:0]         window_mean;
    logic signed [PCT_W-1:0]   altitude_percent;

    // predictor state
    logic [DATA_W-1:0]  ring_q [WINDOW_LEN];
    int                 slot_q;
    int                 total_q;
    logic [DATA_W-1:0]  zero_level_q;
    logic [DATA_W-1:0]  span_q;

    logic [DATA_W-1:0]  samples_to_send [$];
    reading_t           expected_readings [$];

    int  tx_idle_pct  = 0;
    int  rx_stall_pct = 0;
    int  rx_hold_req  = 0;
    int  rx_hold_left = 0;
    bit  in_taken     = 1'b0;
    int  fail_count   = 0;

    adc_moving_mean_altitude_percent_core #(
        .WINDOW_LEN (WINDOW_LEN)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .sample           (sample),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .window_mean      (window_mean),
        .altitude_percent (altitude_percent)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ring update, rounded mean and signed percentage
    function automatic reading_t predict_reading(input logic [DATA_W-1:0] s);
        reading_t r;
        int mean;
        int span;
        int zl;
        int pct;
        total_q        = total_q - int'(ring_q[slot_q]) + int'(s);
        ring_q[slot_q] = s;
        slot_q         = (slot_q == WINDOW_LEN - 1) ? 0 : slot_q + 1;
        mean           = ((2 * total_q + WINDOW_LEN) / 2) / WINDOW_LEN;
        // zero span counts as one
        span           = (span_q == '0) ? 1 : int'(span_q);
        zl             = int'(zero_level_q);
        pct            = ((zl - mean) * PCT_SCALE) / span;
        r.mean         = mean[DATA_W-1:0];
        r.pct          = pct[PCT_W-1:0];
        return r;
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == amm_pkg::REG_ZERO_LEVEL)
        begin
            zero_level_q = val;
        end
        else if (idx == amm_pkg::REG_ONE_VOLT_SPAN)
        begin
            span_q = val;
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // block idle: nothing queued, offered or outstanding
    task automatic wait_drained();
        do @(posedge clk);
        while (samples_to_send.size() != 0 || in_valid || expected_readings.size() != 0);
    endtask

    // accepted item: predict its reading
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            expected_readings.push_back(predict_reading(sample));
            in_taken = 1'b1;
        end
    end

    // sample driver
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_taken)
        begin
            in_taken = 1'b0;
            if (samples_to_send.size() != 0 && $urandom_range(99) >= tx_idle_pct)
            begin
                in_valid <= 1'b1;
                sample   <= samples_to_send.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver hold-off counter
    always @(posedge clk)
    begin
        if (rx_hold_req != 0)
        begin
            rx_hold_left = rx_hold_req;
            rx_hold_req  = 0;
        end
        else if (rx_hold_left != 0)
        begin
            rx_hold_left--;
        end
    end

    // result ready
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= (rx_hold_left == 0) && ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // result checker
    always @(posedge clk)
    begin : check_readings
        reading_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_readings.size() == 0)
            begin
                $error("unexpected result item: window_mean %0d altitude_percent %0d",
                       window_mean, altitude_percent);
                fail_count++;
            end
            else
            begin
                want = expected_readings.pop_front();
                if (window_mean !== want.mean)
                begin
                    $error("window_mean mismatch: expected %0d, got %0d",
                           want.mean, window_mean);
                    fail_count++;
                end
                if (altitude_percent !== want.pct)
                begin
                    $error("altitude_percent mismatch: expected %0d, got %0d",
                           want.pct, altitude_percent);
                    fail_count++;
                end
            end
        end
    end

    // stimulus
    initial
    begin : stimulus
        int ph;
        int k;
        int pick;
        for (k = 0; k < WINDOW_LEN; k++)
        begin
            ring_q[k] = '0;
        end
        slot_q       = 0;
        total_q      = 0;
        zero_level_q = amm_pkg::ZERO_LEVEL_RESET;
        span_q       = amm_pkg::SPAN_RESET;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset registers, alternating bits, then a full window at the top
        samples_to_send.push_back(DATA_W'(12'h555));
        samples_to_send.push_back(DATA_W'(12'hAAA));
        for (k = 0; k < WINDOW_LEN; k++)
        begin
            samples_to_send.push_back(SAMPLE_MAX);
        end
        wait_drained();

        // zero span, unmapped indexes ignored, most negative percentage
        write_reg(amm_pkg::REG_ONE_VOLT_SPAN, '0);
        write_reg(CFG_UNMAPPED_FIRST, '1);
        write_reg(CFG_UNMAPPED_LAST, DATA_W'(7));
        @(posedge clk);
        samples_to_send.push_back(SAMPLE_MAX);
        for (k = 0; k < WINDOW_LEN; k++)
        begin
            samples_to_send.push_back('0);
        end
        wait_drained();

        // most positive percentage
        write_reg(amm_pkg::REG_ZERO_LEVEL, '1);
        write_reg(amm_pkg::REG_ONE_VOLT_SPAN, DATA_W'(1));
        @(posedge clk);
        samples_to_send.push_back('0);
        wait_drained();

        // random phases over several settings and idling patterns
        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                1:
                begin
                    write_reg(amm_pkg::REG_ZERO_LEVEL, '1);
                    write_reg(amm_pkg::REG_ONE_VOLT_SPAN, DATA_W'(1));
                end
                2:
                begin
                    write_reg(amm_pkg::REG_ZERO_LEVEL, '0);
                    write_reg(amm_pkg::REG_ONE_VOLT_SPAN, '1);
                end
                3:
                begin
                    write_reg(amm_pkg::REG_ZERO_LEVEL, DATA_W'($urandom_range(0, 4095)));
                    write_reg(amm_pkg::REG_ONE_VOLT_SPAN, '0);
                end
                default:
                begin
                    write_reg(amm_pkg::REG_ZERO_LEVEL, DATA_W'($urandom_range(0, 4095)));
                    write_reg(amm_pkg::REG_ONE_VOLT_SPAN, DATA_W'($urandom_range(1, 4095)));
                end
            endcase
            write_reg(CFG_INDEX_W'($urandom_range(CFG_UNMAPPED_FIRST, CFG_UNMAPPED_LAST)),
                      DATA_W'($urandom));
            @(posedge clk);
            case (ph % 4)
                0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1:       begin tx_idle_pct = 81; rx_stall_pct = 0;  end
                2:       begin tx_idle_pct = 0;  rx_stall_pct = 81; end
                default: begin tx_idle_pct = 38; rx_stall_pct = 38; end
            endcase
            // samples lean toward the rails so full-scale windows occur
            for (k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                begin
                    samples_to_send.push_back('0);
                end
                else if (pick == 1)
                begin
                    samples_to_send.push_back(SAMPLE_MAX);
                end
                else
                begin
                    samples_to_send.push_back(DATA_W'($urandom_range(0, 4095)));
                end
            end
            // long receiver hold-off while the sender keeps offering
            if (ph == 4)
            begin
                @(negedge clk);
                rx_hold_req = HOLD_OFF_CYCLES;
            end
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("adc_moving_mean_altitude_percent_core_tb OK");
        end
        else
        begin
            $display("adc_moving_mean_altitude_percent_core_tb NOT OK");
        end
        $finish;
    end

    // run time limit
    initial
    begin
        #5_000_000;
        $display("adc_moving_mean_altitude_percent_core_tb NOT OK");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/amm_pkg.sv
hw/rtl/amm_ram.sv
hw/rtl/adc_moving_mean_altitude_percent_core.sv
tb/sv/adc_moving_mean_altitude_percent_core_tb.sv
